/* src/rmq_pkg.sv */
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE = 1 << FRAC_BITS;
  // 0.01 rounded to nearest in the fixed-point format.
  localparam int THRESH = (ONE + 50) / 100;

  localparam int RAD_W = 17;
  localparam int D_W = 17;
  localparam int SQ_W = 16;

  localparam int SQRT_STAGES = 4;
  localparam int SQRT_PER = SQ_W / SQRT_STAGES;

  localparam int QUO_W = 15;
  localparam int DIV_STAGES = 5;
  localparam int DIV_PER = QUO_W / DIV_STAGES;
  localparam int NUM_W = 32;
  localparam int DEN_W = SQ_W + 1;

  typedef struct packed {
    logic signed [15:0] first_axis_x;
    logic signed [15:0] first_axis_y;
    logic signed [15:0] first_axis_z;
    logic signed [15:0] second_axis_x;
    logic signed [15:0] second_axis_y;
    logic signed [15:0] second_axis_z;
    logic signed [15:0] third_axis_x;
    logic signed [15:0] third_axis_y;
    logic signed [15:0] third_axis_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_t;

  typedef enum logic [1:0] {
    BIG_W,
    BIG_X,
    BIG_Y,
    BIG_Z
  } big_e;

  // The three components other than the large one, in w, x, y, z order.
  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    big_e                bigpos;
  } side_t;

endpackage

/* src/rmq_prep.sv */
`timescale 1ns / 1ps

module rmq_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rmq_pkg::in_t              data_i,
  output logic                      valid_o,
  output logic [rmq_pkg::RAD_W-1:0] rad_o,
  output rmq_pkg::side_t            side_o
);

  localparam logic signed [18:0] OneS = 19'(rmq_pkg::ONE);
  localparam logic signed [18:0] ThreshS = 19'(rmq_pkg::THRESH);

  logic signed [18:0] a0, a1, a2, b0, b1, b2, c0, c1, c2;
  logic signed [18:0] trace, rad_s;
  logic [rmq_pkg::RAD_W-1:0] rad_d, rad_q;
  rmq_pkg::side_t side_d, side_q;
  logic valid_q;

  assign a0 = 19'(data_i.first_axis_x);
  assign a1 = 19'(data_i.first_axis_y);
  assign a2 = 19'(data_i.first_axis_z);
  assign b0 = 19'(data_i.second_axis_x);
  assign b1 = 19'(data_i.second_axis_y);
  assign b2 = 19'(data_i.second_axis_z);
  assign c0 = 19'(data_i.third_axis_x);
  assign c1 = 19'(data_i.third_axis_y);
  assign c2 = 19'(data_i.third_axis_z);

  assign trace = a0 + b1 + c2 + OneS;

  always_comb begin
    side_d = '0;
    if (trace > ThreshS) begin
      rad_s = trace;
      side_d.bigpos = rmq_pkg::BIG_W;
      side_d.d[0] = rmq_pkg::D_W'(b2 - c1);
      side_d.d[1] = rmq_pkg::D_W'(c0 - a2);
      side_d.d[2] = rmq_pkg::D_W'(a1 - b0);
    end else if (a0 > b1 && a0 > c2) begin
      rad_s = OneS + a0 - b1 - c2;
      side_d.bigpos = rmq_pkg::BIG_X;
      side_d.d[0] = rmq_pkg::D_W'(b2 - c1);
      side_d.d[1] = rmq_pkg::D_W'(b0 + a1);
      side_d.d[2] = rmq_pkg::D_W'(c0 + a2);
    end else if (b1 > c2) begin
      rad_s = OneS + b1 - a0 - c2;
      side_d.bigpos = rmq_pkg::BIG_Y;
      side_d.d[0] = rmq_pkg::D_W'(c0 - a2);
      side_d.d[1] = rmq_pkg::D_W'(b0 + a1);
      side_d.d[2] = rmq_pkg::D_W'(c1 + b2);
    end else begin
      rad_s = OneS + c2 - a0 - b1;
      side_d.bigpos = rmq_pkg::BIG_Z;
      side_d.d[0] = rmq_pkg::D_W'(a1 - b0);
      side_d.d[1] = rmq_pkg::D_W'(c0 + a2);
      side_d.d[2] = rmq_pkg::D_W'(c1 + b2);
    end
    // A radicand at or below zero is clamped to one LSB.
    if (rad_s <= 19'sd0) begin
      rad_d = rmq_pkg::RAD_W'(1);
    end else begin
      rad_d = rad_s[rmq_pkg::RAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

/* src/rmq_sqrt.sv */
`timescale 1ns / 1ps

module rmq_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rmq_pkg::RAD_W-1:0] rad_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [rmq_pkg::SQ_W-1:0]  sq_o,
  output rmq_pkg::side_t            side_o
);

  localparam int NW = 2 * rmq_pkg::SQ_W;
  localparam int RW = rmq_pkg::SQ_W + 4;
  localparam int NS = rmq_pkg::SQRT_STAGES;

  logic [NS-1:0] valid_q;
  logic [NW-1:0] n_d [NS];
  logic [NW-1:0] n_q [NS];
  logic [RW-1:0] rem_d [NS];
  logic [RW-1:0] rem_q [NS];
  logic [rmq_pkg::SQ_W-1:0] root_d [NS];
  logic [rmq_pkg::SQ_W-1:0] root_q [NS];
  rmq_pkg::side_t side_q [NS];

  // Digit-by-digit square root of rad << FRAC_BITS, SQRT_PER (four) result bits per stage.
  always_comb begin
    logic [NW-1:0] n_t;
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    logic [rmq_pkg::SQ_W-1:0] root_t;
    int i;
    for (int st = 0; st < NS; st++) begin
      if (st == 0) begin
        n_t    = NW'({rad_i, rmq_pkg::FRAC_BITS'(0)});
        rem_t  = '0;
        root_t = '0;
      end else begin
        n_t    = n_q[st-1];
        rem_t  = rem_q[st-1];
        root_t = root_q[st-1];
      end
      for (int k = 0; k < rmq_pkg::SQRT_PER; k++) begin
        i = rmq_pkg::SQ_W - 1 - st * rmq_pkg::SQRT_PER - k;
        rem_t = {rem_t[RW-3:0], n_t[2*i +: 2]};
        trial = RW'({root_t, 2'b01});
        if (rem_t >= trial) begin
          rem_t  = rem_t - trial;
          root_t = {root_t[rmq_pkg::SQ_W-2:0], 1'b1};
        end else begin
          root_t = {root_t[rmq_pkg::SQ_W-2:0], 1'b0};
        end
      end
      n_d[st]    = n_t;
      rem_d[st]  = rem_t;
      root_d[st] = root_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int st = 0; st < NS; st++) begin
        n_q[st]    <= n_d[st];
        rem_q[st]  <= rem_d[st];
        root_q[st] <= root_d[st];
        side_q[st] <= (st == 0) ? side_i : side_q[(st == 0) ? 0 : st - 1];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign sq_o    = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

/* src/rmq_div.sv */
`timescale 1ns / 1ps

module rmq_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rmq_pkg::D_W-1:0]   mag_i,
  input  logic [rmq_pkg::SQ_W-1:0]  sq_i,
  output logic [rmq_pkg::QUO_W-1:0] quo_o
);

  localparam int NS = rmq_pkg::DIV_STAGES + 1;
  localparam int NW = rmq_pkg::NUM_W;
  localparam int QW = rmq_pkg::QUO_W;
  localparam logic [QW-1:0] OneQ = QW'(rmq_pkg::ONE);

  logic [NW-1:0] rem_d [NS];
  logic [NW-1:0] rem_q [NS];
  logic [rmq_pkg::DEN_W-1:0] den_q [NS];
  logic [QW-1:0] quo_d [NS];
  logic [QW-1:0] quo_q [NS];
  logic [NS-1:0] ovf_q;
  logic [NW-1:0] num;
  logic [rmq_pkg::DEN_W-1:0] den;
  logic ovf_d;

  // Rounded quotient: (mag * ONE + sq) / (2 * sq).
  assign num   = NW'({mag_i, rmq_pkg::FRAC_BITS'(0)}) + NW'(sq_i);
  assign den   = {sq_i, 1'b0};
  assign ovf_d = num >= NW'({den, QW'(0)});

  always_comb begin
    logic [NW-1:0] rem_t;
    logic [NW-1:0] dv;
    logic [QW-1:0] quo_t;
    int b;
    rem_d[0] = num;
    quo_d[0] = '0;
    for (int st = 1; st < NS; st++) begin
      rem_t = rem_q[st-1];
      quo_t = quo_q[st-1];
      for (int j = 0; j < rmq_pkg::DIV_PER; j++) begin
        b  = QW - 1 - (st - 1) * rmq_pkg::DIV_PER - j;
        dv = NW'(den_q[st-1]) << b;
        if (rem_t >= dv) begin
          rem_t    = rem_t - dv;
          quo_t[b] = 1'b1;
        end
      end
      rem_d[st] = rem_t;
      quo_d[st] = quo_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int st = 0; st < NS; st++) begin
        rem_q[st] <= rem_d[st];
        quo_q[st] <= quo_d[st];
        if (st == 0) begin
          den_q[st] <= den;
          ovf_q[st] <= ovf_d;
        end else begin
          den_q[st] <= den_q[st-1];
          ovf_q[st] <= ovf_q[st-1];
        end
      end
    end
  end

  assign quo_o = (ovf_q[NS-1] || quo_q[NS-1] > OneQ) ? OneQ : quo_q[NS-1];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_data_i   (nine Q1.14 matrix entries)
// out      output     out_valid_o/out_stall_i out_data_o (quaternion w, x, y, z, Q1.14)
//
// One item enters per cycle unless a stalled result holds the pipeline; each item passes through
// the prep register, the square root (4 stages), the three parallel dividers (6 stages) and the output register.
// Reset clears only the valid bits; the datapath registers are not reset.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.

module rotation_matrix_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmq_pkg::out_t out_data_o
);

  localparam int DL = rmq_pkg::DIV_STAGES + 1;
  localparam int QW = rmq_pkg::QUO_W;
  localparam logic [QW-1:0] OneQ = QW'(rmq_pkg::ONE);
  localparam logic signed [15:0] OneS = 16'(rmq_pkg::ONE);

  typedef struct packed {
    rmq_pkg::big_e  bigpos;
    logic [2:0]     neg;
    logic [QW-1:0]  big;
  } tail_t;

  logic en;
  logic prep_valid;
  logic [rmq_pkg::RAD_W-1:0] prep_rad;
  rmq_pkg::side_t prep_side;
  logic sqrt_valid;
  logic [rmq_pkg::SQ_W-1:0] sq;
  rmq_pkg::side_t sqrt_side;
  logic [rmq_pkg::D_W-1:0] mag [3];
  logic [QW-1:0] quo [3];
  logic [rmq_pkg::SQ_W:0] big_full;
  tail_t tail_d;
  tail_t tail_q [DL];
  logic [DL-1:0] dly_valid_q;
  logic signed [15:0] comp [3];
  logic signed [15:0] big_s;
  rmq_pkg::out_t out_d, out_q;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  rmq_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .rad_o   (prep_rad),
    .side_o  (prep_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .rad_i   (prep_rad),
    .side_i  (prep_side),
    .valid_o (sqrt_valid),
    .sq_o    (sq),
    .side_o  (sqrt_side)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign mag[g] = sqrt_side.d[g][rmq_pkg::D_W-1] ? rmq_pkg::D_W'(-sqrt_side.d[g])
                                                   : sqrt_side.d[g];
    rmq_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mag[g]),
      .sq_i  (sq),
      .quo_o (quo[g])
    );
  end

  // The large component is half the root, rounded half up, then clamped to one.
  assign big_full = ({1'b0, sq} + 17'd1) >> 1;

  always_comb begin
    tail_d.bigpos = sqrt_side.bigpos;
    for (int j = 0; j < 3; j++) begin
      tail_d.neg[j] = sqrt_side.d[j][rmq_pkg::D_W-1];
    end
    tail_d.big = (big_full > 17'(rmq_pkg::ONE)) ? OneQ : big_full[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      dly_valid_q <= {dly_valid_q[DL-2:0], sqrt_valid};
      out_valid_q <= dly_valid_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail_d;
      for (int st = 1; st < DL; st++) begin
        tail_q[st] <= tail_q[st-1];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      comp[j] = tail_q[DL-1].neg[j] ? -16'(quo[j]) : 16'(quo[j]);
    end
    big_s = 16'(tail_q[DL-1].big);
    case (tail_q[DL-1].bigpos)
      rmq_pkg::BIG_W: out_d = '{big_s, comp[0], comp[1], comp[2]};
      rmq_pkg::BIG_X: out_d = '{comp[0], big_s, comp[1], comp[2]};
      rmq_pkg::BIG_Y: out_d = '{comp[0], comp[1], big_s, comp[2]};
      rmq_pkg::BIG_Z: out_d = '{comp[0], comp[1], comp[2], big_s};
      default:        out_d = '{big_s, comp[0], comp[1], comp[2]};
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.quat_w <= OneS && out_q.quat_w >= -OneS &&
                     out_q.quat_x <= OneS && out_q.quat_x >= -OneS &&
                     out_q.quat_y <= OneS && out_q.quat_y >= -OneS &&
                     out_q.quat_z <= OneS && out_q.quat_z >= -OneS))
    else $error("quaternion component outside unit range");

  a_out_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.quat_w != 16'sd0 || out_q.quat_x != 16'sd0 ||
                     out_q.quat_y != 16'sd0 || out_q.quat_z != 16'sd0))
    else $error("all quaternion components are zero");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dly_valid_q))
    else $error("divider valid bits moved during a stall");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  rmq_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  rmq_pkg::out_t  out_data_o;

  rmq_pkg::out_t expected_quats[$];
  int    error_count;
  int    idle_cycles;
  int    send_idle_pct;
  int    recv_idle_pct;

  rotation_matrix_to_quaternion DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint isqrt(longint n);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - res - bitv;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp_unit(longint v);
    longint hi;
    longint lo;
    hi = (rmq_pkg::ONE < 32767) ? rmq_pkg::ONE : 32767;
    lo = (rmq_pkg::ONE < 32768) ? -rmq_pkg::ONE : -32768;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[15:0];
  endfunction

  // Shepperd-style branch choice: the trace when it exceeds THRESH, else the largest diagonal entry.
  function automatic rmq_pkg::out_t predict_quat(rmq_pkg::in_t m);
    longint a0, a1, a2, b0, b1, b2, c0, c1, c2;
    longint trace, r, sq;
    longint d[4];
    longint q[4];
    rmq_pkg::big_e bigpos;
    rmq_pkg::out_t res;
    a0 = m.first_axis_x;  a1 = m.first_axis_y;  a2 = m.first_axis_z;
    b0 = m.second_axis_x; b1 = m.second_axis_y; b2 = m.second_axis_z;
    c0 = m.third_axis_x;  c1 = m.third_axis_y;  c2 = m.third_axis_z;
    trace = a0 + b1 + c2 + rmq_pkg::ONE;
    d[0] = 0;
    if (trace > rmq_pkg::THRESH) begin
      r = trace; bigpos = rmq_pkg::BIG_W;
      d[1] = b2 - c1; d[2] = c0 - a2; d[3] = a1 - b0;
    end else if (a0 > b1 && a0 > c2) begin
      r = rmq_pkg::ONE + a0 - b1 - c2; bigpos = rmq_pkg::BIG_X;
      d[0] = b2 - c1; d[2] = b0 + a1; d[3] = c0 + a2;
    end else if (b1 > c2) begin
      r = rmq_pkg::ONE + b1 - a0 - c2; bigpos = rmq_pkg::BIG_Y;
      d[0] = c0 - a2; d[1] = b0 + a1; d[3] = c1 + b2;
    end else begin
      r = rmq_pkg::ONE + c2 - a0 - b1; bigpos = rmq_pkg::BIG_Z;
      d[0] = a1 - b0; d[1] = c0 + a2; d[2] = c1 + b2;
    end
    if (r <= 0) r = 1;
    sq = isqrt(r <<< rmq_pkg::FRAC_BITS);
    if (sq == 0) sq = 1;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(bigpos)) q[i] = (sq + 1) >>> 1;
      else q[i] = round_div(d[i] * rmq_pkg::ONE, 2 * sq);
    end
    res.quat_w = clamp_unit(q[0]);
    res.quat_x = clamp_unit(q[1]);
    res.quat_y = clamp_unit(q[2]);
    res.quat_z = clamp_unit(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // The valid stays high on return; idle cycles of the next call or wait_drained take it down.
  task automatic send_matrix(rmq_pkg::in_t m);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_quats.push_back(predict_quat(m));
  endtask

  function automatic rmq_pkg::in_t make_matrix(int v0, int v1, int v2, int v3, int v4,
                                               int v5, int v6, int v7, int v8);
    rmq_pkg::in_t m;
    m = {v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0],
         v5[15:0], v6[15:0], v7[15:0], v8[15:0]};
    return m;
  endfunction

  // Receiver stall and result checking.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          rmq_pkg::out_t want;
          want = expected_quats.pop_front();
          if (out_data_o.quat_w !== want.quat_w)
            report_mismatch("quat_w", out_data_o.quat_w, want.quat_w);
          if (out_data_o.quat_x !== want.quat_x)
            report_mismatch("quat_x", out_data_o.quat_x, want.quat_x);
          if (out_data_o.quat_y !== want.quat_y)
            report_mismatch("quat_y", out_data_o.quat_y, want.quat_y);
          if (out_data_o.quat_z !== want.quat_z)
            report_mismatch("quat_z", out_data_o.quat_z, want.quat_z);
        end
      end
      out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int p;
    int n;
    p = rmq_pkg::ONE;
    n = -rmq_pkg::ONE;
    send_matrix(make_matrix(p, 0, 0, 0, p, 0, 0, 0, p));       // identity
    send_matrix(make_matrix(p, 0, 0, 0, n, 0, 0, 0, n));       // x branch
    send_matrix(make_matrix(n, 0, 0, 0, p, 0, 0, 0, n));       // y branch
    send_matrix(make_matrix(n, 0, 0, 0, n, 0, 0, 0, p));       // z branch
    send_matrix(make_matrix(n, 0, 0, 0, n, 0, 0, 0, n));       // tie, z wins
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, n));       // tie between x and y
    send_matrix(make_matrix(n / 2, 0, 0, 0, n / 2, 0, 0, 0, 0)); // trace exactly zero
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0,
                            rmq_pkg::THRESH - rmq_pkg::ONE));     // at threshold
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0,
                            rmq_pkg::THRESH - rmq_pkg::ONE + 1)); // just above
    send_matrix(make_matrix(0, p, 0, n, 0, 0, 0, 0, p));       // 90 degrees about z
    // Extreme entries and saturating components.
    send_matrix(make_matrix(n, p, p, p, n, p, p, p, n));
    send_matrix(make_matrix(n, n, n, n, n, n, n, n, n));
    send_matrix(make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, 32767, -32768));
    send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767));
    send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
    send_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_random(int count);
    rmq_pkg::in_t m;
    int  v[9];
    for (int k = 0; k < count; k++) begin
      for (int j = 0; j < 9; j++) begin
        case ($urandom_range(9))
          0:       v[j] = $urandom_range(65535) - 32768;
          1:       v[j] = $urandom_range(1) ? rmq_pkg::ONE : -rmq_pkg::ONE;
          default: v[j] = $urandom_range(2 * rmq_pkg::ONE) - rmq_pkg::ONE;
        endcase
      end
      // Bias the diagonal so every branch is reached often.
      if ($urandom_range(1)) begin
        v[0] = -($urandom_range(rmq_pkg::ONE));
        v[4] = -($urandom_range(rmq_pkg::ONE));
        v[8] = -($urandom_range(rmq_pkg::ONE));
      end
      m = make_matrix(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
      send_matrix(m);
    end
  endtask

  initial begin
    error_count   = 0;
    idle_cycles   = 0;
    send_idle_pct = 14;
    recv_idle_pct = 74;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(120);
    wait_drained();
    send_idle_pct = 74;
    recv_idle_pct = 14;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
